// ===== rtl/bwec_pkg.sv =====
// Package: shared constants, types and codes of the binned weighted efficiency counter.
package bwec_pkg;

    // Table geometry.
    localparam int PHOTON_ETA_BINS = 2;
    localparam int JET_ETA_BINS    = 3;
    localparam int PT_BINS         = 32;
    localparam int NBINS           = PHOTON_ETA_BINS * JET_ETA_BINS * PT_BINS;
    localparam int BIN_W           = $clog2(NBINS);

    // Field widths.
    localparam int WEIGHT_W = 24;
    localparam int SUM_W    = 48;
    localparam int SQ_W     = 64;
    localparam int EFF_W    = 18;
    localparam int ERR_W    = 32;
    localparam int STAT_W   = 2;

    // Width of the shared multiplier and divider words.
    localparam int MW    = 192;
    localparam int DCNT_W = 6;
    localparam logic [DCNT_W-1:0] EFF_STEPS = DCNT_W'(17);
    localparam logic [DCNT_W-1:0] ERR_STEPS = DCNT_W'(32);

    localparam logic [EFF_W-1:0] EFF_POS_MAX = 18'h1FFFF;
    localparam logic [EFF_W-1:0] EFF_NEG_MAX = 18'h20000;

    // Action codes.
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PZERO = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TZERO = 2'd2;

    // One row of the bin table.
    typedef struct packed {
        logic [SUM_W-1:0] tw;
        logic [SQ_W-1:0]  tw2;
        logic [SUM_W-1:0] pw;
        logic [SQ_W-1:0]  pw2;
    } t_row;

    typedef enum logic [3:0] {
        S_IDLE, S_REC, S_LOAD, S_ELD, S_EDIV, S_MUL, S_XLD, S_XDIV, S_DONE
    } t_state;

    // Operand selection for the shift-add multiplier.
    typedef enum logic [2:0] {
        MSEL_FF, MSEL_XPE2, MSEL_PP, MSEL_YFE2, MSEL_TT, MSEL_ZZ
    } t_msel;

    // Where a finished product is kept.
    typedef enum logic [1:0] {
        SAVE_NONE, SAVE_A, SAVE_B, SAVE_DEN
    } t_save;

    // Operand selection for the divider.
    typedef enum logic {
        DSEL_EFF, DSEL_ERR
    } t_dsel;

    typedef struct packed {
        logic  cap;
        logic  rec_wr;
        logic  load;
        logic  div_ld;
        t_dsel div_sel;
        logic  div_step;
        logic  eff_save;
        logic  mul_ld;
        t_msel mul_sel;
        logic  mul_step;
        t_save save;
        logic  out_ld;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic mul_done;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/bwec_if.sv =====
// Interfaces: the input item channel and the result channel.
interface bwec_in_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic                           photon_eta_bin;
    logic [1:0]                     jet_eta_bin;
    logic [4:0]                     photon_pt_bin;
    logic                           passed;
    logic signed [23:0]             weight;

    modport source (output valid, action, photon_eta_bin, jet_eta_bin, photon_pt_bin,
                    passed, weight, input ready);
    modport sink   (input valid, action, photon_eta_bin, jet_eta_bin, photon_pt_bin,
                    passed, weight, output ready);
endinterface

interface bwec_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] efficiency;
    logic [31:0]        error_squared;
    logic [1:0]         status;

    modport source (output valid, efficiency, error_squared, status, input ready);
    modport sink   (input valid, efficiency, error_squared, status, output ready);
endinterface

// ===== rtl/binned_weighted_efficiency_counter_top.sv =====
// Top level of the binned weighted efficiency counter.
//
// Input channel i_in carries record and read items; output channel o_out carries one
// result per read item (efficiency, squared error, status). Records give no result.
// A transfer happens on a rising edge with valid and ready both high.
// A record reads the bin row on the transfer edge and writes it back with the
// new sums on the next edge, after which the next item is taken.
// A read takes its bin row, a 17-step divider pass for the efficiency, six products
// on a shift-add multiplier that consumes one multiplier bit per cycle (bits of |F|,
// Pe2, |P|, |Fe2|, |T| and T^2), a 32-step divider pass and a result load.
// A read whose passed or total sum is zero goes from its row load straight to the result load.
// One item is worked on at a time; the result register lets the next item in
// while a result waits. If the receiver stalls, a finished read waits for the
// result register to drain before it completes.
// Reset clears the controller, the result valid bit and the bin valid bits, so
// every bin reads as empty at once; no clearing pass is needed.
module binned_weighted_efficiency_counter_top (
    input logic         i_clk,
    input logic         i_rst_n,
    bwec_in_if.sink     i_in,
    bwec_out_if.source  o_out
);
    import bwec_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bwec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    bwec_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_pe        (i_in.photon_eta_bin),
        .i_je        (i_in.jet_eta_bin),
        .i_pt        (i_in.photon_pt_bin),
        .i_passed    (i_in.passed),
        .i_weight    (i_in.weight),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_eff       (o_out.efficiency),
        .o_err       (o_out.error_squared),
        .o_stat      (o_out.status)
    );

endmodule

// ===== rtl/bwec_ctrl.sv =====
// Controller: sequences record updates and the efficiency and error calculation.
module bwec_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_action,
    input  bwec_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output bwec_pkg::t_cmd o_cmd
);
    import bwec_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_mstep, n_mstep;

    // State and multiply step registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mstep <= '0;
        end else begin
            r_state <= n_state;
            r_mstep <= n_mstep;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_mstep    = r_mstep;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = (i_action == ACT_READ) ? S_LOAD : S_REC;
                end
            end
            S_REC: begin
                o_cmd.rec_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = i_sts.special ? S_DONE : S_ELD;
            end
            S_ELD: begin
                o_cmd.div_ld  = 1'b1;
                o_cmd.div_sel = DSEL_EFF;
                n_state       = S_EDIV;
            end
            S_EDIV: begin
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.eff_save = 1'b1;
                    o_cmd.mul_ld   = 1'b1;
                    o_cmd.mul_sel  = MSEL_FF;
                    n_mstep        = '0;
                    n_state        = S_MUL;
                end
            end
            S_MUL: begin
                if (!i_sts.mul_done) begin
                    o_cmd.mul_step = 1'b1;
                end else begin
                    n_mstep = r_mstep + 3'd1;
                    // Each finished product but the last starts the next one; the last is kept as the denominator.
                    case (r_mstep)
                        3'd0: begin
                            o_cmd.mul_ld  = 1'b1;
                            o_cmd.mul_sel = MSEL_XPE2;
                        end
                        3'd1: begin
                            o_cmd.save    = SAVE_A;
                            o_cmd.mul_ld  = 1'b1;
                            o_cmd.mul_sel = MSEL_PP;
                        end
                        3'd2: begin
                            o_cmd.mul_ld  = 1'b1;
                            o_cmd.mul_sel = MSEL_YFE2;
                        end
                        3'd3: begin
                            o_cmd.save    = SAVE_B;
                            o_cmd.mul_ld  = 1'b1;
                            o_cmd.mul_sel = MSEL_TT;
                        end
                        3'd4: begin
                            o_cmd.mul_ld  = 1'b1;
                            o_cmd.mul_sel = MSEL_ZZ;
                        end
                        default: begin
                            o_cmd.save = SAVE_DEN;
                            n_state    = S_XLD;
                        end
                    endcase
                end
            end
            S_XLD: begin
                o_cmd.div_ld  = 1'b1;
                o_cmd.div_sel = DSEL_ERR;
                n_state       = S_XDIV;
            end
            S_XDIV: begin
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/bwec_dp.sv =====
// Datapath: bin table, record update, shift-add multiplier, divider and result register.
module bwec_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bwec_pkg::t_cmd     i_cmd,
    output bwec_pkg::t_sts     o_sts,
    input  logic               i_pe,
    input  logic [1:0]         i_je,
    input  logic [4:0]         i_pt,
    input  logic               i_passed,
    input  logic signed [23:0] i_weight,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [17:0] o_eff,
    output logic [31:0]        o_err,
    output logic [1:0]         o_stat
);
    import bwec_pkg::*;

    // Bin table and its per-entry valid bits.
    t_row                 mem [NBINS];
    logic [NBINS-1:0]     r_vld;
    t_row                 r_rd;
    logic                 r_rd_vld;
    logic [BIN_W-1:0]     r_idx;
    logic                 r_inr;
    logic                 r_passed;
    logic signed [WEIGHT_W-1:0] r_weight;

    logic [BIN_W-1:0]     w_idx;
    logic                 w_inr;
    t_row                 w_row;
    t_row                 n_row;
    logic signed [SUM_W-1:0] w_sq;
    logic [SUM_W-1:0]     w_wext;

    // Operands of the error calculation.
    logic [SUM_W-1:0]     r_pmag, r_tmag;
    logic [SUM_W:0]       r_fmag;
    logic [SQ_W-1:0]      r_pe2, r_fe2;
    logic                 r_fe2_neg, r_neg;
    logic [STAT_W-1:0]    r_stat;
    logic [SUM_W-1:0]     w_pmag, w_tmag;
    logic signed [SUM_W:0] w_f;

    // Multiplier and divider state.
    logic [MW-1:0]        r_ma, r_mb, r_acc, r_na, r_nb, r_den;
    logic [MW-1:0]        r_rem, r_dden;
    logic [MW-1:0]        w_rem2, w_num;
    logic [ERR_W-1:0]     r_q;
    logic [DCNT_W-1:0]    r_dcnt;
    logic                 r_sat;
    logic                 w_rnd;
    logic [EFF_W-1:0]     r_eff;
    logic [EFF_W-1:0]     w_qe;
    logic [ERR_W-1:0]     w_err;

    // Bin address of the offered item.
    always_comb begin
        w_inr = (int'(i_pe) < PHOTON_ETA_BINS) && (int'(i_je) < JET_ETA_BINS) &&
                (int'(i_pt) < PT_BINS);
        w_idx = w_inr ? BIN_W'((int'(i_pe) * JET_ETA_BINS + int'(i_je)) * PT_BINS +
                               int'(i_pt)) : '0;
    end

    // Table read on accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_rd     <= mem[w_idx];
            r_idx    <= w_idx;
            r_passed <= i_passed;
            r_weight <= i_weight;
        end
    end

    // Table write on record.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec_wr && r_inr) begin
            mem[r_idx] <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_inr    <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_rd_vld <= r_vld[w_idx];
                r_inr    <= w_inr;
            end
            if (i_cmd.rec_wr && r_inr) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    // A never-written entry reads as zero; an out-of-range read gives an empty bin.
    assign w_row = (r_rd_vld && r_inr) ? r_rd : '0;

    // Record accumulation.
    always_comb begin
        w_sq   = r_weight * r_weight;
        w_wext = {{(SUM_W-WEIGHT_W){r_weight[WEIGHT_W-1]}}, r_weight};
        n_row     = w_row;
        n_row.tw  = w_row.tw + w_wext;
        n_row.tw2 = w_row.tw2 + {{(SQ_W-SUM_W){1'b0}}, w_sq};
        if (r_passed) begin
            n_row.pw  = w_row.pw + w_wext;
            n_row.pw2 = w_row.pw2 + {{(SQ_W-SUM_W){1'b0}}, w_sq};
        end
    end

    // Magnitudes of the sums for a read.
    always_comb begin
        w_pmag = w_row.pw[SUM_W-1] ? (~w_row.pw + 1'b1) : w_row.pw;
        w_tmag = w_row.tw[SUM_W-1] ? (~w_row.tw + 1'b1) : w_row.tw;
        w_f    = $signed({w_row.tw[SUM_W-1], w_row.tw}) -
                 $signed({w_row.pw[SUM_W-1], w_row.pw});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pmag    <= w_pmag;
            r_tmag    <= w_tmag;
            r_fmag    <= w_f[SUM_W] ? (~w_f + 1'b1) : w_f;
            r_pe2     <= w_row.pw2;
            r_fe2_neg <= w_row.tw2 < w_row.pw2;
            r_fe2     <= (w_row.tw2 >= w_row.pw2) ? (w_row.tw2 - w_row.pw2)
                                                  : (w_row.pw2 - w_row.tw2);
            r_neg     <= w_row.pw[SUM_W-1] ^ w_row.tw[SUM_W-1];
            if (w_row.pw == '0) begin
                r_stat <= STAT_PZERO;
            end else if (w_row.tw == '0) begin
                r_stat <= STAT_TZERO;
            end else begin
                r_stat <= STAT_OK;
            end
        end
    end

    // Shift-add multiplier: one multiplier bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_ld) begin
            r_acc <= '0;
            case (i_cmd.mul_sel)
                MSEL_FF: begin
                    r_ma <= MW'(r_fmag);
                    r_mb <= MW'(r_fmag);
                end
                MSEL_XPE2: begin
                    r_ma <= r_acc;
                    r_mb <= MW'(r_pe2);
                end
                MSEL_PP: begin
                    r_ma <= MW'(r_pmag);
                    r_mb <= MW'(r_pmag);
                end
                MSEL_YFE2: begin
                    r_ma <= r_acc;
                    r_mb <= MW'(r_fe2);
                end
                MSEL_TT: begin
                    r_ma <= MW'(r_tmag);
                    r_mb <= MW'(r_tmag);
                end
                default: begin
                    r_ma <= r_acc;
                    r_mb <= r_acc;
                end
            endcase
        end else if (i_cmd.mul_step) begin
            if (r_mb[0]) begin
                r_acc <= r_acc + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
    end

    // Finished products kept for the error numerator and denominator.
    always_ff @(posedge i_clk) begin
        case (i_cmd.save)
            SAVE_A:   r_na  <= r_acc;
            SAVE_B:   r_nb  <= r_acc;
            SAVE_DEN: r_den <= r_acc;
            default: ;
        endcase
    end

    // Error numerator: a negative value ends as zero.
    always_comb begin
        if (!r_fe2_neg) begin
            w_num = r_na + r_nb;
        end else if (r_na >= r_nb) begin
            w_num = r_na - r_nb;
        end else begin
            w_num = '0;
        end
    end

    // Restoring divider: one quotient bit per cycle.
    assign w_rem2 = r_rem << 1;
    assign w_rnd  = w_rem2 >= r_dden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_ld) begin
            r_dcnt <= (i_cmd.div_sel == DSEL_EFF) ? EFF_STEPS : ERR_STEPS;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_ld) begin
            r_q <= '0;
            if (i_cmd.div_sel == DSEL_EFF) begin
                r_rem  <= MW'(r_pmag);
                r_dden <= MW'({r_tmag, 1'b0});
                r_sat  <= MW'(r_pmag) >= MW'({r_tmag, 1'b0});
            end else begin
                r_rem  <= w_num;
                r_dden <= r_den;
                r_sat  <= w_num >= r_den;
            end
        end else if (i_cmd.div_step) begin
            if (w_rnd) begin
                r_rem <= w_rem2 - r_dden;
                r_q   <= {r_q[ERR_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2;
                r_q   <= {r_q[ERR_W-2:0], 1'b0};
            end
        end
    end

    // Rounded, saturated efficiency.
    assign w_qe = {1'b0, r_q[EFF_W-2:0]} + EFF_W'(w_rnd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.eff_save) begin
            if (r_neg) begin
                r_eff <= (r_sat || w_qe > EFF_NEG_MAX) ? EFF_NEG_MAX : (~w_qe + 1'b1);
            end else begin
                r_eff <= (r_sat || w_qe > EFF_POS_MAX) ? EFF_POS_MAX : w_qe;
            end
        end
    end

    // Rounded, saturated squared error.
    always_comb begin
        if (r_sat || (&r_q && w_rnd)) begin
            w_err = '1;
        end else begin
            w_err = r_q + ERR_W'(w_rnd);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_stat <= r_stat;
            if (r_stat == STAT_OK) begin
                o_eff <= r_eff;
                o_err <= w_err;
            end else begin
                o_eff <= '0;
                o_err <= '0;
            end
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.special  = (w_row.pw == '0) || (w_row.tw == '0);
        o_sts.mul_done = (r_mb == '0);
        o_sts.div_done = (r_dcnt == '0);
        o_sts.out_busy = o_out_valid && !i_out_ready;
    end

endmodule

// ===== rtl/bwec_chk.sv =====
// Checker: port-level assertions for the top level, attached by a bind.
module bwec_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_action,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [17:0] i_eff,
    input logic [31:0] i_err,
    input logic [1:0]  i_stat
);
    import bwec_pkg::*;

    // A result held under a stall keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_eff) &&
        $stable(i_err) && $stable(i_stat))
        else $error("result changed while stalled");

    // A bin with a zero passed or total sum returns zeros.
    a_zero_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stat != STAT_OK |-> i_eff == '0 && i_err == '0)
        else $error("special status with nonzero values");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while another is in progress");

    // No result straight out of reset.
    a_rst_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // A record item gives no result in the next cycle unless one was pending.
    a_rec_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_action == ACT_RECORD && !i_out_valid
        |=> !i_out_valid)
        else $error("record produced a result");

endmodule

bind binned_weighted_efficiency_counter_top bwec_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_action    (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_eff       (o_out.efficiency),
    .i_err       (o_out.error_squared),
    .i_stat      (o_out.status)
);
